@@ src/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the json string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // result status codes
    localparam logic [2:0] ST_BYTE   = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_UNTERM = 3'd2;
    localparam logic [2:0] ST_BADHEX = 3'd3;
    localparam logic [2:0] ST_NOQUOT = 3'd4;

    // utf-8 encoding constants
    localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
    localparam logic [7:0]  LEAD_TWO      = 8'hC0;
    localparam logic [7:0]  LEAD_THREE    = 8'hE0;
    localparam logic [7:0]  CONT_MARK     = 8'h80;

    localparam int QUEUE_DEPTH = 4;

    // one queued job: a single result, or a code point to encode
    typedef struct packed {
        logic        is_cp;
        logic [15:0] value;
        logic [2:0]  status;
    } jsu_entry_t;

endpackage

`default_nettype wire

@@ src/jsu_front.sv @@
// ----------------------------------------------------------------------------
// jsu_front
// Accepts text bytes, tracks the string phase and queues result jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               at_end,
    output jsu_pkg::jsu_entry_t     entry,
    output logic                    push
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } phase_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_point_reg, code_point_next;
    logic [4:0]  hex;
    logic [15:0] cp_full;

    // bit 4 marks a valid hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = e;
        endcase
        return r;
    endfunction

    assign hex     = hex_value(data_byte);
    assign cp_full = {code_point_reg[11:0], hex[3:0]};

    always_comb
    begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_point_next = code_point_reg;
        push            = 1'b0;
        entry           = '0;
        if (accept)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (at_end || data_byte != CH_QUOTE)
                begin
                    push         = 1'b1;
                    entry.status = jsu_pkg::ST_NOQUOT;
                end
                else
                begin
                    phase_next = PH_STR;
                end
            end
            else if (at_end)
            begin
                phase_next      = PH_IDLE;
                hex_count_next  = '0;
                code_point_next = '0;
                push            = 1'b1;
                entry.status    = jsu_pkg::ST_UNTERM;
            end
            else if (phase_reg == PH_STR)
            begin
                if (data_byte == CH_QUOTE)
                begin
                    phase_next   = PH_IDLE;
                    push         = 1'b1;
                    entry.status = jsu_pkg::ST_DONE;
                end
                else if (data_byte == CH_BSL)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    push        = 1'b1;
                    entry.value = {8'h00, data_byte};
                end
            end
            else if (phase_reg == PH_ESC)
            begin
                if (data_byte == CH_U)
                begin
                    phase_next      = PH_HEX;
                    hex_count_next  = '0;
                    code_point_next = '0;
                end
                else
                begin
                    phase_next  = PH_STR;
                    push        = 1'b1;
                    entry.value = {8'h00, unescape(data_byte)};
                end
            end
            else
            begin
                if (!hex[4])
                begin
                    phase_next      = PH_IDLE;
                    hex_count_next  = '0;
                    code_point_next = '0;
                    push            = 1'b1;
                    entry.status    = jsu_pkg::ST_BADHEX;
                end
                else if (hex_count_reg != 2'd3)
                begin
                    code_point_next = cp_full;
                    hex_count_next  = hex_count_reg + 2'd1;
                end
                else
                begin
                    phase_next      = PH_STR;
                    hex_count_next  = '0;
                    code_point_next = '0;
                    push            = 1'b1;
                    entry.is_cp     = 1'b1;
                    entry.value     = cp_full;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hex_count_reg  <= '0;
            code_point_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

    a_hex_count_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HEX |-> hex_count_reg == 2'd0 && code_point_reg == 16'd0)
        else $error("hex state left over outside escape");

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("job queued without an accepted word");

    a_cp_only_from_hex: assert property (@(posedge clk) disable iff (!rst_n)
        push && entry.is_cp |=> phase_reg == PH_STR)
        else $error("code point job did not return to string phase");

endmodule

`default_nettype wire

@@ src/jsu_queue.sv @@
// ----------------------------------------------------------------------------
// jsu_queue
// Short register queue of result jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire jsu_pkg::jsu_entry_t push_entry,
    input  wire logic                pop,
    output jsu_pkg::jsu_entry_t      head,
    output logic                     empty,
    output logic                     full
);

    localparam int PW = $clog2(jsu_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(jsu_pkg::QUEUE_DEPTH + 1);

    jsu_pkg::jsu_entry_t slot_reg [jsu_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(jsu_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(jsu_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

@@ src/jsu_back.sv @@
// ----------------------------------------------------------------------------
// jsu_back
// Expands queued jobs into result words and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire jsu_pkg::jsu_entry_t head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [7:0]               out_byte,
    output logic [2:0]               status,
    output logic                     last
);

    logic [1:0] idx_reg;
    logic [1:0] final_idx;
    logic [7:0] byte_sel;
    logic       load;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [2:0] status_reg;
    logic       last_reg;

    // index of the last utf-8 word for the head job
    always_comb
    begin
        if (!head.is_cp || head.value < jsu_pkg::CP_TWO_BYTE)
            final_idx = 2'd0;
        else if (head.value < jsu_pkg::CP_THREE_BYTE)
            final_idx = 2'd1;
        else
            final_idx = 2'd2;
    end

    always_comb
    begin
        byte_sel = head.value[7:0];
        case (final_idx)
            2'd1:
            begin
                if (idx_reg == 2'd0)
                    byte_sel = jsu_pkg::LEAD_TWO | {3'b000, head.value[10:6]};
                else
                    byte_sel = jsu_pkg::CONT_MARK | {2'b00, head.value[5:0]};
            end
            2'd2:
            begin
                if (idx_reg == 2'd0)
                    byte_sel = jsu_pkg::LEAD_THREE | {4'h0, head.value[15:12]};
                else if (idx_reg == 2'd1)
                    byte_sel = jsu_pkg::CONT_MARK | {2'b00, head.value[11:6]};
                else
                    byte_sel = jsu_pkg::CONT_MARK | {2'b00, head.value[5:0]};
            end
            default: byte_sel = head.value[7:0];
        endcase
    end

    assign load = !empty && (!out_valid_reg || !out_stall);
    assign pop  = load && (idx_reg == final_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (pop)
                idx_reg <= '0;
            else if (load)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_sel;
            status_reg   <= head.status;
            last_reg     <= (idx_reg == final_idx);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("word index out of range");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != jsu_pkg::ST_BYTE |-> last_reg)
        else $error("status word not marked last");

    a_mid_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> !empty)
        else $error("job expansion lost its queue entry");

endmodule

`default_nettype wire

@@ src/json_string_unescape_utf8.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a json string literal byte stream into utf-8 result words.
// ----------------------------------------------------------------------------
// Takes one text word per cycle, starting with the opening quote, and returns
// decoded bytes with a status (byte, closed, unterminated, bad hex, missing
// quote); last marks the final word caused by each input word. Words that
// cause no result (opening quote, backslash, u, first three hex digits) are
// absorbed. The front accepts one word per cycle whenever the four-entry job
// queue is not full; the back emits one result word per cycle while out_stall
// is low, so a \uXXXX escape of two or three utf-8 bytes holds the back for
// one word per byte; a result passes a queue slot and the output register.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       at_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [2:0]      status,
    output logic            last
);

    jsu_pkg::jsu_entry_t push_entry;
    jsu_pkg::jsu_entry_t head;
    logic push, pop, empty, full, accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .at_end    (at_end),
        .entry     (push_entry),
        .push      (push)
    );

    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

endmodule

`default_nettype wire
